/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, masked while rst_n is low
`define HTHB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define HTHB_ASSERT_IMP(lbl, ante, cons, msg) \
  `HTHB_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define HTHB_ASSERT_NEXT(lbl, ante, cons, msg) \
  `HTHB_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* rtl/hthb_pkg.sv */
`default_nettype none

package hthb_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;

  localparam logic       ACT_INSERT = 1'b0;
  localparam logic       ACT_BUILD  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [31:0] freq;
    logic [15:0] idx;
  } heap_entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_UP_WR,
    S_POP_TOP,
    S_POP_LAST,
    S_POP_MOV,
    S_DN_CHK,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_DN_WR,
    S_SUM,
    S_EMIT
  } hthb_state_t;

endpackage

`default_nettype wire

/* rtl/huffman_tree_heap_builder_unit.sv */
// Channel | Dir | tdata                                       | tuser              | tlast
// in_     | in  | leaf_freq, leaf_index, first_slot (64 bits) | action             | -
// out_    | out | node_freq, first_idx, second_idx, node_slot | status, node_valid | last
//
// Insert: sift-up from the new last slot, one parent compare per heap level climbed.
// Build, per merged node: two pops (each moves the last entry to the top and sifts
// it down level by level), a sum, one result beat and a push (sift-up as above).
// Every step is paced by the heap RAM's single registered read port.
// Synchronous active-low reset empties the heap; RAM contents are not cleared.
// in_tready is high only when idle; a stalled result beat stalls the sequencer.
`default_nettype none

`include "assert_macros.svh"

module huffman_tree_heap_builder_unit
  import hthb_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // leaf_freq, leaf_index, first_slot
  input  wire logic [0:0]  in_tuser,   // action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // node_freq, first_idx, second_idx, node_slot
  output logic [2:0]       out_tuser,  // status, node_valid
  output logic             out_tlast
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  hthb_state_t state_r, state_nxt;

  heap_entry_t heap_mem [MAX_ENTRIES];
  heap_entry_t rd_data_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  heap_entry_t   wr_data;

  logic [CW-1:0] cnt_r;
  logic [AW-1:0] pos_r, mpos_r;
  heap_entry_t   mov_r, child_r, a_r, b_r;
  logic [31:0]   sum_r;
  logic [15:0]   slot_r;
  logic          sel_r, node_r;
  logic [1:0]    status_r;

  logic          out_valid_r, out_last_r;
  logic [79:0]   out_data_r;
  logic [2:0]    out_user_r;

  logic          in_fire, out_free, out_load, full, up_move, dn_move, r_better;
  logic [CW:0]   l_w, r_w, cnt_ext;
  logic [AW-1:0] par_w, last_addr;
  logic [CW-1:0] cnt_m1;
  logic [32:0]   sum_w;
  logic          act;
  logic          ins_ok;

  assign act       = in_tuser[0];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign full      = (cnt_r == CW'(MAX_ENTRIES));
  assign ins_ok    = in_fire && (act == ACT_INSERT) && !full;

  assign cnt_ext   = (CW+1)'(cnt_r);
  assign l_w       = ((CW+1)'(pos_r) << 1) | (CW+1)'(1);
  assign r_w       = l_w + (CW+1)'(1);
  assign par_w     = (pos_r - AW'(1)) >> 1;
  assign cnt_m1    = cnt_r - CW'(1);
  assign last_addr = cnt_m1[AW-1:0];
  assign sum_w     = {1'b0, a_r.freq} + {1'b0, b_r.freq};

  assign up_move   = (rd_data_r.freq > mov_r.freq);
  assign dn_move   = (child_r.freq < mov_r.freq);
  assign r_better  = (rd_data_r.freq < child_r.freq);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (act == ACT_BUILD) begin
            state_nxt = (cnt_r < CW'(2)) ? S_EMIT : S_POP_TOP;
          end else begin
            state_nxt = full ? S_EMIT : S_UP_CHK;
          end
        end
      end
      S_UP_CHK:   state_nxt = (pos_r == '0) ? S_UP_WR : S_UP_CMP;
      S_UP_CMP:   state_nxt = up_move ? S_UP_CHK : S_UP_WR;
      S_UP_WR: begin
        if (node_r) begin
          state_nxt = (cnt_r > CW'(1)) ? S_POP_TOP : S_IDLE;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_POP_TOP:  state_nxt = S_POP_LAST;
      S_POP_LAST: state_nxt = S_POP_MOV;
      S_POP_MOV:  state_nxt = S_DN_CHK;
      S_DN_CHK:   state_nxt = (l_w < cnt_ext) ? S_DN_L : S_DN_WR;
      S_DN_L:     state_nxt = (r_w < cnt_ext) ? S_DN_R : S_DN_CMP;
      S_DN_R:     state_nxt = S_DN_CMP;
      S_DN_CMP:   state_nxt = dn_move ? S_DN_CHK : S_DN_WR;
      S_DN_WR:    state_nxt = sel_r ? S_SUM : S_POP_TOP;
      S_SUM:      state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_nxt = node_r ? S_UP_CHK : S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = pos_r;
    wr_data  = mov_r;
    out_load = 1'b0;
    unique case (state_r)
      S_UP_CHK:   rd_addr = par_w;
      S_UP_CMP: begin
        wr_en   = up_move;
        wr_data = rd_data_r;
      end
      S_UP_WR:    wr_en = 1'b1;
      S_POP_LAST: rd_addr = last_addr;
      S_DN_CHK:   rd_addr = l_w[AW-1:0];
      S_DN_L:     rd_addr = r_w[AW-1:0];
      S_DN_CMP: begin
        wr_en   = dn_move;
        wr_data = child_r;
      end
      S_DN_WR:    wr_en = 1'b1;
      S_EMIT:     out_load = out_free;
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= heap_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      sel_r   <= 1'b0;
      node_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            mov_r  <= {in_tdata[31:0], in_tdata[47:32]};
            pos_r  <= cnt_r[AW-1:0];
            slot_r <= in_tdata[63:48];
            sel_r  <= 1'b0;
            if (act == ACT_BUILD) begin
              node_r   <= (cnt_r >= CW'(2));
              status_r <= (cnt_r == '0) ? ST_EMPTY : ST_OK;
            end else begin
              node_r   <= 1'b0;
              status_r <= full ? ST_FULL : ST_OK;
              if (!full) begin
                cnt_r <= cnt_r + CW'(1);
              end
            end
          end
        end
        S_UP_CMP: begin
          if (up_move) begin
            pos_r <= par_w;
          end
        end
        S_POP_LAST: begin
          if (sel_r) begin
            b_r <= rd_data_r;
          end else begin
            a_r <= rd_data_r;
          end
          cnt_r <= cnt_m1;
          pos_r <= '0;
        end
        S_POP_MOV:  mov_r <= rd_data_r;
        S_DN_L: begin
          child_r <= rd_data_r;
          mpos_r  <= l_w[AW-1:0];
        end
        S_DN_R: begin
          if (r_better) begin
            child_r <= rd_data_r;
            mpos_r  <= r_w[AW-1:0];
          end
        end
        S_DN_CMP: begin
          if (dn_move) begin
            pos_r <= mpos_r;
          end
        end
        S_DN_WR:    sel_r <= !sel_r;
        S_SUM:      sum_r <= sum_w[32] ? 32'hFFFF_FFFF : sum_w[31:0];
        S_EMIT: begin
          if (out_free && node_r) begin
            mov_r  <= {sum_r, slot_r};
            pos_r  <= cnt_r[AW-1:0];
            cnt_r  <= cnt_r + CW'(1);
            slot_r <= slot_r + 16'd1;
          end
        end
        default: begin
          sel_r <= sel_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= node_r ? {slot_r, b_r.idx, a_r.idx, sum_r} : '0;
      out_user_r <= {node_r, status_r};
      out_last_r <= node_r ? (cnt_r == '0) : 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  `HTHB_ASSERT(a_cnt_range, cnt_r <= CW'(MAX_ENTRIES), "heap count beyond capacity")
  `HTHB_ASSERT_NEXT(a_ins_grow, ins_ok, cnt_r == $past(cnt_r) + CW'(1), "heap did not grow")
  `HTHB_ASSERT_IMP(a_pop_pair, (state_r == S_POP_TOP) && !sel_r, cnt_r >= CW'(2), "too few")
  `HTHB_ASSERT_IMP(a_dn_desc, state_r == S_DN_CMP, mpos_r > pos_r, "child not below parent")

endmodule

`default_nettype wire
